// File: hw/rtl/des_cipher_with_modes_macros.svh
// Assertion macros used by the checker of the DES block
`ifndef DES_CIPHER_WITH_MODES_MACROS_SVH
`define DES_CIPHER_WITH_MODES_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DES_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define DES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// condition holds at every edge out of reset
`define DES_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/des_pkg.sv
// DES tables, permutation helpers and shared codes
package des_pkg;

    typedef enum logic [1:0] {
        CHAIN_ECB = 2'd0,
        CHAIN_CBC = 2'd1,
        CHAIN_CFB = 2'd2,
        CHAIN_OFB = 2'd3
    } chain_mode_t;

    localparam int unsigned ADDR_W = 5;

    typedef enum logic [ADDR_W-1:0] {
        REG_KEY  = 5'd0,
        REG_MODE = 5'd8,
        REG_IV   = 5'd16
    } reg_addr_t;

    localparam int unsigned ROUNDS = 16;

    typedef logic [6:0] tab_entry_t;

    localparam tab_entry_t IP_TAB [64] = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
    localparam tab_entry_t FP_TAB [64] = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
    localparam tab_entry_t E_TAB [48] = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
    localparam tab_entry_t P_TAB [32] = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
    localparam tab_entry_t PC1_TAB [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4};
    localparam tab_entry_t PC2_TAB [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    // total left rotation of each key half after each round
    localparam logic [4:0] SHIFT_TAB [16] = '{
        1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};

    localparam logic [3:0] SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // table positions count from 1 at the MSB
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_TAB[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_TAB[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_TAB[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_TAB[i])];
        return r;
    endfunction

    function automatic logic [27:0] rotl28(input logic [27:0] c, input logic [4:0] n);
        logic [27:0] r;
        r = (c << n) | (c >> (5'd28 - n));
        return r;
    endfunction

    function automatic logic [47:0] subkey(input logic [55:0] cd, input int rnd);
        logic [27:0] c;
        logic [27:0] d;
        c = rotl28(cd[55:28], SHIFT_TAB[rnd]);
        d = rotl28(cd[27:0], SHIFT_TAB[rnd]);
        return perm_pc2({c, d});
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [5:0]  six;
        logic [31:0] s;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(E_TAB[i])];
        x = x ^ k;
        for (int i = 0; i < 8; i++)
        begin
            six = x[47-6*i -: 6];
            s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(P_TAB[i])];
        return p;
    endfunction

endpackage

// File: hw/rtl/des_if.sv
// Stream interfaces for plaintext words in and ciphertext words out
interface des_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_in;
    logic        restart;
    modport source (output valid, output data_in, output restart, input ready);
    modport sink (input valid, input data_in, input restart, output ready);
endinterface

interface des_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_out;
    modport source (output valid, output data_out, input ready);
    modport sink (input valid, input data_out, output ready);
endinterface

// File: hw/rtl/des_round.sv
// One DES Feistel round
module des_round (
    input  logic [31:0] l_in,
    input  logic [31:0] r_in,
    input  logic [47:0] key,
    output logic [31:0] l_out,
    output logic [31:0] r_out
);
    assign l_out = r_in;
    assign r_out = des_pkg::feistel(r_in, key) ^ l_in;
endmodule

// File: hw/rtl/des_core.sv
// Combinational DES encryption: IP, sixteen rounds, final permutation
module des_core (
    input  logic [63:0] block,
    input  logic [63:0] key,
    output logic [63:0] cipher
);
    logic [55:0] cd;
    logic [63:0] lr;
    logic [31:0] l_s [des_pkg::ROUNDS+1];
    logic [31:0] r_s [des_pkg::ROUNDS+1];

    assign cd = des_pkg::perm_pc1(key);
    assign lr = des_pkg::perm_ip(block);
    assign l_s[0] = lr[63:32];
    assign r_s[0] = lr[31:0];

    for (genvar g = 0; g < des_pkg::ROUNDS; g++)
    begin : g_round
        des_round u_round (
            .l_in  (l_s[g]),
            .r_in  (r_s[g]),
            .key   (des_pkg::subkey(cd, g)),
            .l_out (l_s[g+1]),
            .r_out (r_s[g+1])
        );
    end

    // halves swap before the final permutation
    assign cipher = des_pkg::perm_fp({r_s[des_pkg::ROUNDS], l_s[des_pkg::ROUNDS]});
endmodule

// File: hw/rtl/des_cipher_with_modes.sv
// DES encryption block with ECB, CBC, CFB-8 and OFB chaining
//
// Channels: src_ch takes a plaintext word (data_in, restart flag), dst_ch
// returns one ciphertext word (data_out) for every word taken. In CFB only
// the low byte of data_in is used and data_out carries the cipher byte with
// the upper bits zero.
// Registers on the APB port: key at 0x00, mode at 0x08, IV at 0x10; write
// them only while no word is in flight.
// A word taken from src_ch sits in the input register and moves on to the
// result register, which drives data_out, once that register is empty or
// dst_ch takes its word. Throughput is one word per cycle in every mode
// while dst_ch does not stall: the full sixteen-round DES cone and the
// chaining update sit between the input register and the result register,
// so the chaining value is ready for the next word at once.
// Reset clears key, mode, IV, chaining value and all valid flags.
// When dst_ch stalls, the result holds and the input register keeps its
// word; src_ch ready drops only while both are full.
module des_cipher_with_modes (
    input  logic                        clk,
    input  logic                        rst_n,
    des_in_if.sink                      src_ch,
    des_out_if.source                   dst_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [des_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    logic [63:0]          key_reg;
    des_pkg::chain_mode_t mode_reg;
    logic [63:0]          iv_reg;
    logic [63:0]          chain_reg;
    logic [63:0]          chain_next;

    logic                 s1_valid_reg;
    logic [63:0]          s1_data_reg;
    logic                 s1_restart_reg;
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;
    logic [63:0]          out_data_next;

    logic                 s1_adv;
    logic                 cfg_wr;
    logic [63:0]          chain_cur;
    logic [63:0]          core_in;
    logic [63:0]          core_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr)
            des_pkg::REG_KEY:  prdata = key_reg;
            des_pkg::REG_MODE: prdata = {62'd0, mode_reg};
            des_pkg::REG_IV:   prdata = iv_reg;
            default:           prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= 64'd0;
            mode_reg <= des_pkg::CHAIN_ECB;
            iv_reg   <= 64'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                des_pkg::REG_KEY:  key_reg  <= pwdata;
                des_pkg::REG_MODE: mode_reg <= des_pkg::chain_mode_t'(pwdata[1:0]);
                des_pkg::REG_IV:   iv_reg   <= pwdata;
                default:           ;
            endcase
        end
    end

    assign s1_adv       = !out_valid_reg || dst_ch.ready;
    assign src_ch.ready = !s1_valid_reg || s1_adv;
    assign dst_ch.valid    = out_valid_reg;
    assign dst_ch.data_out = out_data_reg;

    assign chain_cur = s1_restart_reg ? iv_reg : chain_reg;

    always_comb
    begin
        unique case (mode_reg)
            des_pkg::CHAIN_ECB: core_in = s1_data_reg;
            des_pkg::CHAIN_CBC: core_in = s1_data_reg ^ chain_cur;
            default:            core_in = chain_cur;
        endcase
    end

    des_core u_core (
        .block  (core_in),
        .key    (key_reg),
        .cipher (core_out)
    );

    always_comb
    begin
        unique case (mode_reg)
            des_pkg::CHAIN_ECB:
            begin
                out_data_next = core_out;
                chain_next    = chain_cur;
            end
            des_pkg::CHAIN_CBC:
            begin
                out_data_next = core_out;
                chain_next    = core_out;
            end
            des_pkg::CHAIN_CFB:
            begin
                out_data_next = {56'd0, core_out[63:56] ^ s1_data_reg[7:0]};
                chain_next    = {chain_cur[55:0], core_out[63:56] ^ s1_data_reg[7:0]};
            end
            default:
            begin
                out_data_next = core_out ^ s1_data_reg;
                chain_next    = core_out;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= 64'd0;
        end
        else
        begin
            if (src_ch.ready)
                s1_valid_reg <= src_ch.valid;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
            if (s1_adv && s1_valid_reg)
                chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_ch.ready && src_ch.valid)
        begin
            s1_data_reg    <= src_ch.data_in;
            s1_restart_reg <= src_ch.restart;
        end
        if (s1_adv && s1_valid_reg)
            out_data_reg <= out_data_next;
    end
endmodule

// File: hw/rtl/des_checker.sv
// Port-level checks for the DES block, bound to the top level
`include "des_cipher_with_modes_macros.svh"

module des_assertions (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic pready
);
    `DES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `DES_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready)
    // input only stalls behind a blocked result
    `DES_ASSERT_IMPL(a_stall_only_when_blocked, !in_ready, out_valid && !out_ready)
    `DES_ASSERT_ALWAYS(a_pready, pready)
endmodule

bind des_cipher_with_modes des_assertions u_des_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (src_ch.valid),
    .in_ready  (src_ch.ready),
    .out_valid (dst_ch.valid),
    .out_ready (dst_ch.ready),
    .pready    (pready)
);
